>>> hw/rtl/lru_kv_pkg.sv
`timescale 1ns / 1ps

package lru_kv_pkg;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // all ones, reported where no value or key applies
    localparam logic signed [31:0] NONE_WORD = 32'shFFFF_FFFF;

    localparam int CAP_W = 5;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } rsp_t;

    // recency rank update request
    typedef struct packed {
        logic touch;   // move slot to most recent, age the more recent ones
        logic insert;  // new entry in slot, age every other valid entry
        logic grow;    // insert into a free slot, fill count goes up
    } rank_op_t;

endpackage

>>> hw/rtl/lru_kv_rank.sv
`timescale 1ns / 1ps

module lru_kv_rank
    import lru_kv_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int FW = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [IW-1:0] rd_idx,
    output logic          rd_valid,
    output logic [IW-1:0] rd_age,
    output logic [FW-1:0] fill_count,
    input  logic          op_en,
    input  rank_op_t      op,
    input  logic [IW-1:0] op_slot,
    input  logic [IW-1:0] op_age
);

    logic          valid_reg [MAX_ENTRIES];
    logic          valid_next[MAX_ENTRIES];
    logic [IW-1:0] age_reg   [MAX_ENTRIES];
    logic [IW-1:0] age_next  [MAX_ENTRIES];
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;

    assign rd_valid   = valid_reg[rd_idx];
    assign rd_age     = age_reg[rd_idx];
    assign fill_count = fill_reg;

    always_comb
    begin
        fill_next = fill_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            age_next[i]   = age_reg[i];
        end
        if (op_en)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (IW'(i) == op_slot)
                begin
                    if (op.touch || op.insert)
                    begin
                        valid_next[i] = 1'b1;
                        age_next[i]   = '0;
                    end
                end
                else if (valid_reg[i])
                begin
                    if (op.insert || (op.touch && age_reg[i] < op_age))
                        age_next[i] = age_reg[i] + IW'(1);
                end
            end
            if (op.insert && op.grow)
                fill_next = fill_reg + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                age_reg[i]   <= '0;
            end
            fill_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                valid_reg[i] <= valid_next[i];
                age_reg[i]   <= age_next[i];
            end
            fill_reg <= fill_next;
        end
    end

endmodule

>>> hw/rtl/lru_kv_cache.sv
`timescale 1ns / 1ps

// Fully associative key/value store with least-recently-used replacement.
// A command word (get or put) is taken at a clock edge where start is high and
// busy is low; busy then stays high while one shared key comparator walks the
// key/value memory one entry per cycle. The response word shows on result for
// exactly one cycle with done high, and must be taken then: there is no way to
// hold it off. Between accept and the first cycle a new command can be accepted
// lie the one-entry-per-cycle scan through the single memory read port, the
// compare of the last entry read, and the update state. The done cycle overlaps
// the next accept.
// The capacity register is written through cfg_valid/cfg_data (always ready)
// and must only be changed while the block is idle; values above MAX_ENTRIES
// behave as MAX_ENTRIES and zero turns the store off. Recency ranks and valid
// bits are flops cleared by reset, so no clearing pass is needed.

module lru_key_value_cache
    import lru_kv_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             done,
    output rsp_t             result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CAP_W-1:0] capacity_reg;
    logic [FW-1:0]    eff_cap;

    // latched command word
    cmd_t cmd_reg;

    // key/value memories, one read port each at the scan address
    logic signed [31:0] key_mem[MAX_ENTRIES];
    logic signed [31:0] val_mem[MAX_ENTRIES];
    logic signed [31:0] key_rd_reg;
    logic signed [31:0] val_rd_reg;

    // scan address counter and compare stage
    logic [CW-1:0] cnt_reg;
    logic          issue;
    logic [IW-1:0] rd_addr;
    logic          cmp_valid_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_last;

    // rank lookup at the compared entry
    logic          rk_valid;
    logic [IW-1:0] rk_age;
    logic [FW-1:0] fill_count;

    // scan findings
    logic               hit_found_reg;
    logic [IW-1:0]      hit_slot_reg;
    logic [IW-1:0]      hit_age_reg;
    logic signed [31:0] hit_val_reg;
    logic               free_found_reg;
    logic [IW-1:0]      free_slot_reg;
    logic               vic_found_reg;
    logic [IW-1:0]      vic_slot_reg;
    logic signed [31:0] vic_key_reg;
    logic               hit_now;
    logic               free_now;
    logic               vic_now;

    // update decisions
    logic          is_put;
    logic          cap_on;
    logic          do_touch;
    logic          miss_put;
    logic          use_vic;
    logic          use_free;
    logic          do_ins;
    logic [IW-1:0] ins_slot;
    logic [IW-1:0] upd_slot;
    logic          upd_en;
    rank_op_t      rank_op;

    // response
    rsp_t rsp_next;
    rsp_t rsp_reg;
    logic done_reg;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = rsp_reg;
    assign cfg_ready = 1'b1;

    // capacity register; its effective value is clamped to the physical size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_W'(16);
        else if (cfg_valid && cfg_ready)
            capacity_reg <= cfg_data;
    end

    assign eff_cap = (32'(capacity_reg) > 32'(MAX_ENTRIES)) ? FW'(MAX_ENTRIES)
                                                             : FW'(capacity_reg);

    // sequencer
    assign issue    = (state_reg == ST_SCAN) && (32'(cnt_reg) < MAX_ENTRIES);
    assign rd_addr  = cnt_reg[IW-1:0];
    assign cmp_last = cmp_valid_reg && (cmp_idx_reg == IW'(MAX_ENTRIES - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cmp_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= issue;
            if (state_reg == ST_IDLE)
                cnt_reg <= '0;
            else if (issue)
                cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            cmd_reg <= cmd;
        cmp_idx_reg <= rd_addr;
    end

    // memory read, registered
    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    // shared compare unit: one entry per cycle
    assign hit_now  = cmp_valid_reg && rk_valid && (key_rd_reg == cmd_reg.key)
                      && !hit_found_reg;
    assign free_now = cmp_valid_reg && !rk_valid && !free_found_reg;
    // the least recent valid entry holds rank fill_count - 1
    assign vic_now  = cmp_valid_reg && rk_valid && !vic_found_reg
                      && (FW'(rk_age) == fill_count - FW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end
        else if (state_reg == ST_IDLE)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end
        else
        begin
            if (hit_now)
                hit_found_reg <= 1'b1;
            if (free_now)
                free_found_reg <= 1'b1;
            if (vic_now)
                vic_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_now)
        begin
            hit_slot_reg <= cmp_idx_reg;
            hit_age_reg  <= rk_age;
            hit_val_reg  <= val_rd_reg;
        end
        if (free_now)
            free_slot_reg <= cmp_idx_reg;
        if (vic_now)
        begin
            vic_slot_reg <= cmp_idx_reg;
            vic_key_reg  <= key_rd_reg;
        end
    end

    // update decisions, used in the update cycle
    assign is_put   = (cmd_reg.kind == KIND_PUT);
    assign cap_on   = (eff_cap != '0);
    assign do_touch = cap_on && hit_found_reg;
    assign miss_put = cap_on && !hit_found_reg && is_put;
    assign use_vic  = miss_put && (fill_count >= eff_cap) && vic_found_reg;
    assign use_free = miss_put && !use_vic && free_found_reg;
    assign do_ins   = use_vic || use_free;
    assign ins_slot = use_vic ? vic_slot_reg : free_slot_reg;
    assign upd_slot = do_touch ? hit_slot_reg : ins_slot;
    assign upd_en   = (state_reg == ST_UPDATE);

    assign rank_op.touch  = do_touch;
    assign rank_op.insert = do_ins;
    assign rank_op.grow   = use_free;

    lru_kv_rank #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_rank (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_idx     (cmp_idx_reg),
        .rd_valid   (rk_valid),
        .rd_age     (rk_age),
        .fill_count (fill_count),
        .op_en      (upd_en),
        .op         (rank_op),
        .op_slot    (upd_slot),
        .op_age     (hit_age_reg)
    );

    // memory write port
    always_ff @(posedge clk)
    begin
        if (upd_en && do_ins)
            key_mem[ins_slot] <= cmd_reg.key;
        if (upd_en && (do_ins || (do_touch && is_put)))
            val_mem[upd_slot] <= cmd_reg.value;
    end

    // response word
    always_comb
    begin
        rsp_next.hit         = do_touch;
        rsp_next.read_value  = (do_touch && !is_put) ? hit_val_reg : NONE_WORD;
        rsp_next.evicted     = use_vic;
        rsp_next.evicted_key = use_vic ? vic_key_reg : NONE_WORD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= upd_en;
    end

    always_ff @(posedge clk)
    begin
        if (upd_en)
            rsp_reg <= rsp_next;
    end

`ifndef SYNTHESIS
    // a response only ever follows the update cycle
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPDATE))
        else $error("response word without update cycle");

    // leaving busy always delivers a response word
    a_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("command finished without response word");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.hit && result.evicted))
        else $error("hit and eviction in one response word");

    // fill count stays within the physical size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_count) <= MAX_ENTRIES)
        else $error("fill count beyond store size");
`endif

endmodule

>>> dv/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

    import lru_kv_pkg::*;

    localparam int SLOTS       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 70;

    // result of a get that misses, of a put that inserts without eviction, and of anything at capacity zero
    localparam rsp_t MISS_RSP = '{1'b0, NONE_WORD, 1'b0, NONE_WORD};

    typedef enum logic {ROW_WORD, ROW_CAPACITY} row_op_t;

    // one line of the directed script: a command word or a capacity write
    typedef struct {
        row_op_t          op;
        cmd_t             word;
        logic [CAP_W-1:0] cap;
        bit               typed;   // want holds a hand-written result
        rsp_t             want;
    } script_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cmd_t             cmd = '0;
    logic             done;
    rsp_t             result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;

    // shadow copy of the cache contents and recency ranks
    logic [31:0]      shadow_key [SLOTS];
    logic [31:0]      shadow_val [SLOTS];
    logic             shadow_valid [SLOTS];
    logic [3:0]       shadow_age [SLOTS];
    logic [4:0]       shadow_fill = '0;
    logic [CAP_W-1:0] shadow_cap = 5'd16;

    rsp_t        pending_lookups[$];   // expected result words, oldest first
    script_row_t script[$];
    logic [31:0] key_pool[$];

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_hits = 0;
    int n_evictions = 0;
    int n_cap_writes = 0;
    int stall_cycles = 0;
    bit steady = 1'b0;   // no gaps between command words

    lru_key_value_cache #(
        .MAX_ENTRIES(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // look up one command word in the shadow cache, update it, return the result word
    function automatic rsp_t lru_lookup(cmd_t w);
        rsp_t       r;
        int         found;
        int         victim;
        int         slot;
        logic [4:0] lim;
        logic [3:0] a;
        r = MISS_RSP;
        found = -1;
        victim = -1;
        slot = -1;
        // capacity above the slot count behaves as the slot count
        lim = (shadow_cap > SLOTS) ? 5'(SLOTS) : shadow_cap;
        if (lim != 0)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && shadow_valid[i] && shadow_key[i] == w.key)
                    found = i;
            if (found >= 0)
            begin
                r.hit = 1'b1;
                n_hits++;
                if (w.kind == KIND_GET)
                    r.read_value = shadow_val[found];
                else
                    shadow_val[found] = w.value;
                // move to most recent, entries more recent than it age by one
                a = shadow_age[found];
                for (int i = 0; i < SLOTS; i++)
                    if (shadow_valid[i] && i != found && shadow_age[i] < a)
                        shadow_age[i]++;
                shadow_age[found] = '0;
            end
            else if (w.kind == KIND_PUT)
            begin
                // full, or capacity lowered below the fill: drop the oldest entry
                if (shadow_fill >= lim)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (shadow_valid[i] && (victim < 0 || shadow_age[i] > shadow_age[victim]))
                            victim = i;
                    if (victim >= 0)
                    begin
                        r.evicted = 1'b1;
                        r.evicted_key = shadow_key[victim];
                        shadow_valid[victim] = 1'b0;
                        shadow_fill--;
                        n_evictions++;
                    end
                    slot = victim;
                end
                // otherwise the lowest free slot
                if (slot < 0)
                    for (int i = 0; i < SLOTS; i++)
                        if (slot < 0 && !shadow_valid[i])
                            slot = i;
                if (slot >= 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (shadow_valid[i])
                            shadow_age[i]++;
                    shadow_key[slot] = w.key;
                    shadow_val[slot] = w.value;
                    shadow_valid[slot] = 1'b1;
                    shadow_age[slot] = '0;
                    shadow_fill++;
                end
            end
        end
        return r;
    endfunction

    function automatic void add_word(logic kind, logic [31:0] key, logic [31:0] value,
                                     bit typed, rsp_t want);
        script_row_t r;
        r.op = ROW_WORD;
        r.word = '{kind, key, value};
        r.cap = '0;
        r.typed = typed;
        r.want = want;
        script.push_back(r);
    endfunction

    function automatic void add_capacity(logic [CAP_W-1:0] v);
        script_row_t r;
        r.op = ROW_CAPACITY;
        r.word = '0;
        r.cap = v;
        r.typed = 1'b0;
        r.want = MISS_RSP;
        script.push_back(r);
    endfunction

    // idle cycles before the next command word: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at result word %0d: %s", n_checked, what);
        n_errors++;
    endtask

    // offer one command word until taken, then log its expected result
    task automatic send_word(input cmd_t w, input bit typed, input rsp_t want);
        rsp_t predicted;
        int   gap;
        start <= 1'b1;
        cmd <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = lru_lookup(w);
        pending_lookups.push_back(typed ? want : predicted);
        n_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain all outstanding lookups so the capacity may change
    task automatic wait_idle();
        if (start)
            start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        shadow_cap = v;
        n_cap_writes++;
    endtask

    // result checker: every done cycle must match the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch($sformatf("unexpected result word %h", result));
            else
            begin
                want = pending_lookups.pop_front();
                if (result.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, want %b", result.hit, want.hit));
                if (result.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              result.read_value, want.read_value));
                if (result.evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %b, want %b",
                                              result.evicted, want.evicted));
                if (result.evicted_key !== want.evicted_key)
                    report_mismatch($sformatf("evicted_key %h, want %h",
                                              result.evicted_key, want.evicted_key));
                n_checked++;
            end
        end
    end

    // watchdog: too long without any word moving on any port
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int          caps [PHASES];
        int          lim;
        int          pool_size;
        cmd_t        w;
        script_row_t row;

        foreach (shadow_valid[i])
        begin
            shadow_valid[i] = 1'b0;
            shadow_age[i] = '0;
            shadow_key[i] = '0;
            shadow_val[i] = '0;
        end

        // directed script: reset state, key and value extremes, put hit,
        // eviction, capacity zero, capacity above the slot count, capacity
        // lowered below the fill
        add_word(KIND_GET, 32'h0000_0000, 32'h1234_5678, 1'b1, MISS_RSP);
        add_word(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, MISS_RSP);
        add_word(KIND_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
                 rsp_t'{1'b1, 32'sh7FFF_FFFF, 1'b0, NONE_WORD});
        add_word(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, MISS_RSP);
        // put on a stored key: hit, no read value, nothing evicted
        add_word(KIND_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
                 rsp_t'{1'b1, NONE_WORD, 1'b0, NONE_WORD});
        add_word(KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                 rsp_t'{1'b1, 32'sh0000_0000, 1'b0, NONE_WORD});
        add_word(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, MISS_RSP);
        // two entries at capacity two: a new key pushes out the older one
        add_capacity(5'd2);
        add_word(KIND_PUT, 32'h0000_0005, 32'h0000_0037, 1'b1,
                 rsp_t'{1'b0, NONE_WORD, 1'b1, 32'sh8000_0000});
        // store switched off
        add_capacity(5'd0);
        add_word(KIND_GET, 32'h0000_0005, 32'h0000_0000, 1'b1, MISS_RSP);
        add_word(KIND_PUT, 32'h0000_0009, 32'h0000_0001, 1'b1, MISS_RSP);
        // above the slot count
        add_capacity(5'd31);
        add_word(KIND_PUT, 32'h0000_0009, 32'h0000_0001, 1'b0, MISS_RSP);
        add_word(KIND_PUT, 32'h0000_000A, 32'h0000_0002, 1'b0, MISS_RSP);
        add_word(KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, MISS_RSP);
        add_word(KIND_PUT, 32'h0000_000B, 32'h0000_0003, 1'b0, MISS_RSP);
        // lowered below the fill: old entries stay reachable, each new key evicts one
        add_capacity(5'd1);
        add_word(KIND_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, MISS_RSP);
        add_word(KIND_PUT, 32'h0000_000C, 32'h0000_0004, 1'b0, MISS_RSP);
        add_word(KIND_PUT, 32'h0000_000D, 32'hFFFF_FFFF, 1'b0, MISS_RSP);
        add_word(KIND_GET, 32'h0000_000C, 32'h0000_0000, 1'b0, MISS_RSP);
        add_word(KIND_GET, 32'h0000_000D, 32'h0000_0000, 1'b0, MISS_RSP);
        add_capacity(5'd16);

        caps = '{16, 1, 31, 0, 5, 16, 2, 17, 9, 16};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            row = script[i];
            if (row.op == ROW_CAPACITY)
            begin
                wait_idle();
                write_capacity(row.cap);
            end
            else
                send_word(row.word, row.typed, row.want);
        end

        // random phases, each at its own capacity with a key pool a bit larger
        // than the capacity so that hits and evictions both happen often
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            if (p == 4 || p == 8)
                write_capacity(5'($urandom_range(2, 15)));
            else
                write_capacity(5'(caps[p]));
            steady = (p % 4 == 2);
            lim = (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
            pool_size = lim + $urandom_range(1, 5);
            key_pool.delete();
            for (int k = 0; k < pool_size; k++)
            begin
                case ($urandom_range(0, 11))
                    0: key_pool.push_back(32'h8000_0000);
                    1: key_pool.push_back(32'h7FFF_FFFF);
                    2: key_pool.push_back(32'hFFFF_FFFF);
                    3: key_pool.push_back(32'h0000_0000);
                    default: key_pool.push_back($urandom);
                endcase
            end
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                w.kind = $urandom_range(0, 1) ? KIND_PUT : KIND_GET;
                // now and then a key from outside the pool
                if ($urandom_range(0, 9) == 0)
                    w.key = $urandom;
                else
                    w.key = key_pool[$urandom_range(0, pool_size - 1)];
                w.value = $urandom;
                send_word(w, 1'b0, MISS_RSP);
            end
        end

        // drain, then a short tail for stray result words
        if (start)
            start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);

        $display("covered %0d command words, %0d checked, over %0d capacity settings",
                 n_sent, n_checked, n_cap_writes);
        $display("predicted %0d hits and %0d evictions, %0d mismatches",
                 n_hits, n_evictions, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> lru_key_value_cache.f
hw/rtl/lru_kv_pkg.sv
hw/rtl/lru_kv_rank.sv
hw/rtl/lru_kv_cache.sv
dv/lru_key_value_cache_tb.sv
